>>> rtl/i2cms_pkg.sv
// i2cms_pkg: command codes, sequencer op encoding and small helpers
// shared by the i2c master pin sequencer and its checker
// no dependencies
`timescale 1ns / 1ps

package i2cms_pkg;

    localparam int unsigned CMD_W   = 3;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PHASE_W = 5;

    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ACK   = 3'd5;

    // configuration register indexes
    localparam logic REG_DELAY_TICKS    = 1'b0;
    localparam logic REG_ACK_POLL_LIMIT = 1'b1;

    localparam logic [BYTE_W-1:0] DELAY_TICKS_RST    = 8'd8;
    localparam logic [BYTE_W-1:0] ACK_POLL_LIMIT_RST = 8'd200;

    // first phase index after the write bit loop, the ack poll and ack end phases
    localparam logic [PHASE_W-1:0] WR_BITS_END = 5'd24;
    localparam logic [PHASE_W-1:0] ACK_POLL_PH = 5'd1;
    localparam logic [PHASE_W-1:0] ACK_END_PH  = 5'd2;

    typedef enum logic [5:0] {
        OP_IDLE  = 6'b000001,
        OP_START = 6'b000010,
        OP_STOP  = 6'b000100,
        OP_WRITE = 6'b001000,
        OP_READ  = 6'b010000,
        OP_ACK   = 6'b100000
    } op_t;

    function automatic op_t cmd_to_op(input logic [CMD_W-1:0] c);
        op_t o;
        case (c)
            CMD_START: o = OP_START;
            CMD_STOP:  o = OP_STOP;
            CMD_WRITE: o = OP_WRITE;
            CMD_READ:  o = OP_READ;
            CMD_ACK:   o = OP_ACK;
            default:   o = OP_IDLE;
        endcase
        return o;
    endfunction

    function automatic logic [PHASE_W-1:0] phase_total(input op_t o);
        logic [PHASE_W-1:0] t;
        case (o)
            OP_START: t = 5'd3;
            OP_STOP:  t = 5'd3;
            OP_WRITE: t = 5'd26;
            OP_READ:  t = 5'd18;
            OP_ACK:   t = 5'd3;
            default:  t = 5'd0;
        endcase
        return t;
    endfunction

    // remainder by three for a 5-bit phase, by conditional subtraction
    function automatic logic [1:0] mod3(input logic [PHASE_W-1:0] p);
        logic [PHASE_W-1:0] r;
        r = p;
        if (r >= 5'd24) r = r - 5'd24;
        if (r >= 5'd12) r = r - 5'd12;
        if (r >= 5'd6)  r = r - 5'd6;
        if (r >= 5'd3)  r = r - 5'd3;
        return r[1:0];
    endfunction

endpackage

>>> rtl/i2c_master_pin_sequencer.sv
// i2c_master_pin_sequencer: i2c master that steps scl/sda one tick per word
// depends on i2cms_pkg
// registers from input accept to result word: input reg, then result reg
// throughput: one word per cycle unless stalled; state steps once per word
// in_stall follows out_stall only while both stages hold a word
// reset: async active low, scl/sda state released, idle, config at defaults
`timescale 1ns / 1ps

module i2c_master_pin_sequencer
    import i2cms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [BYTE_W-1:0] cfg_data,
    // input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [BYTE_W-1:0] tx_byte,
    input  logic              sda_in,
    // output channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic              scl_out,
    output logic              sda_out,
    output logic              busy_res,
    output logic              done_res,
    output logic [BYTE_W-1:0] rx_byte,
    output logic              ack_seen
);

    // configuration registers
    logic [BYTE_W-1:0] delay_ticks_reg;
    logic [BYTE_W-1:0] ack_limit_reg;

    // input stage
    logic              s1_valid_reg;
    logic [CMD_W-1:0]  s1_cmd_reg;
    logic [BYTE_W-1:0] s1_tx_reg;
    logic              s1_sda_reg;

    // sequencer state
    op_t                op_reg,    op_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [BYTE_W-1:0]  dcnt_reg,  dcnt_next;
    logic [BYTE_W-1:0]  shreg_reg, shreg_next;
    logic [BYTE_W-1:0]  poll_reg,  poll_next;
    logic               scl_reg,   scl_next;
    logic               sda_reg,   sda_next;
    logic               ack_reg,   ack_next;
    logic [BYTE_W-1:0]  rx_reg,    rx_next;
    logic               done_next;

    // result stage
    logic              out_valid_reg;
    logic              o_scl_reg;
    logic              o_sda_reg;
    logic              o_busy_reg;
    logic              o_done_reg;
    logic [BYTE_W-1:0] o_rx_reg;
    logic              o_ack_reg;

    logic              out_ready;
    logic              s1_move;
    logic              in_take;
    logic [BYTE_W-1:0] hold;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_move   = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_take   = in_valid && !in_stall;
    assign hold      = (delay_ticks_reg == '0) ? BYTE_W'(1) : delay_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_ticks_reg <= DELAY_TICKS_RST;
            ack_limit_reg   <= ACK_POLL_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DELAY_TICKS:    delay_ticks_reg <= cfg_data;
                REG_ACK_POLL_LIMIT: ack_limit_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take || s1_move)
        begin
            s1_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cmd_reg <= cmd;
            s1_tx_reg  <= tx_byte;
            s1_sda_reg <= sda_in;
        end
    end

    // one sequencer tick per word
    always_comb
    begin
        logic do_act;
        logic poll_end;
        do_act     = 1'b0;
        poll_end   = 1'b0;
        op_next    = op_reg;
        phase_next = phase_reg;
        dcnt_next  = dcnt_reg;
        shreg_next = shreg_reg;
        poll_next  = poll_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        rx_next    = rx_reg;
        done_next  = 1'b0;

        if (op_reg == OP_IDLE)
        begin
            if (cmd_to_op(s1_cmd_reg) != OP_IDLE)
            begin
                op_next    = cmd_to_op(s1_cmd_reg);
                phase_next = '0;
                if (s1_cmd_reg == CMD_WRITE) shreg_next = s1_tx_reg;
                if (s1_cmd_reg == CMD_ACK)
                begin
                    ack_next  = 1'b0;
                    poll_next = '0;
                end
                do_act    = 1'b1;
                dcnt_next = hold;
            end
        end
        else if (op_reg == OP_ACK && phase_reg == ACK_POLL_PH)
        begin
            if (!s1_sda_reg)
            begin
                ack_next = 1'b1;
                poll_end = 1'b1;
            end
            else if (poll_reg >= ack_limit_reg)
            begin
                poll_end = 1'b1;
            end
            else
            begin
                poll_next = poll_reg + 1'b1;
            end
            if (poll_end)
            begin
                phase_next = ACK_END_PH;
                do_act     = 1'b1;
                dcnt_next  = hold;
            end
        end
        else if (dcnt_reg > BYTE_W'(1))
        begin
            dcnt_next = dcnt_reg - 1'b1;
        end
        else
        begin
            phase_next = phase_reg + 1'b1;
            if (phase_next < phase_total(op_reg))
            begin
                do_act = 1'b1;
                // the poll phase runs without a hold count
                if (op_reg == OP_ACK && phase_next == ACK_POLL_PH) dcnt_next = '0;
                else                                                dcnt_next = hold;
            end
            else
            begin
                if (op_reg == OP_READ) rx_next = shreg_reg;
                op_next    = OP_IDLE;
                phase_next = '0;
                dcnt_next  = '0;
                done_next  = 1'b1;
            end
        end

        // pin action of the phase just entered
        if (do_act)
        begin
            case (op_next)
                OP_START:
                begin
                    if (phase_next == 5'd0)      sda_next = 1'b1;
                    else if (phase_next == 5'd1) scl_next = 1'b1;
                    else                         sda_next = 1'b0;
                end
                OP_STOP:
                begin
                    if (phase_next == 5'd0)      sda_next = 1'b0;
                    else if (phase_next == 5'd1) scl_next = 1'b1;
                    else                         sda_next = 1'b1;
                end
                OP_WRITE:
                begin
                    if (phase_next < WR_BITS_END)
                    begin
                        case (mod3(phase_next))
                            2'd0: scl_next = 1'b0;
                            2'd1:
                            begin
                                sda_next   = shreg_next[BYTE_W-1];
                                shreg_next = {shreg_next[BYTE_W-2:0], 1'b0};
                            end
                            default: scl_next = 1'b1;
                        endcase
                    end
                    else if (phase_next == WR_BITS_END)
                    begin
                        scl_next = 1'b0;
                    end
                    else
                    begin
                        sda_next = 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (phase_next == 5'd0)      scl_next = 1'b0;
                    else if (phase_next == 5'd1) sda_next = 1'b1;
                    else if (!phase_next[0])     scl_next = 1'b1;
                    else
                    begin
                        shreg_next = {shreg_next[BYTE_W-2:0], s1_sda_reg};
                        scl_next   = 1'b0;
                    end
                end
                OP_ACK:
                begin
                    if (phase_next == 5'd0)            scl_next = 1'b1;
                    else if (phase_next == ACK_END_PH) scl_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg    <= OP_IDLE;
            phase_reg <= '0;
            dcnt_reg  <= '0;
            shreg_reg <= '0;
            poll_reg  <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ack_reg   <= 1'b0;
            rx_reg    <= '0;
        end
        else if (s1_move)
        begin
            op_reg    <= op_next;
            phase_reg <= phase_next;
            dcnt_reg  <= dcnt_next;
            shreg_reg <= shreg_next;
            poll_reg  <= poll_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
            rx_reg    <= rx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            o_scl_reg  <= scl_next;
            o_sda_reg  <= sda_next;
            o_busy_reg <= (op_next != OP_IDLE);
            o_done_reg <= done_next;
            o_rx_reg   <= rx_next;
            o_ack_reg  <= ack_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign scl_out   = o_scl_reg;
    assign sda_out   = o_sda_reg;
    assign busy_res  = o_busy_reg;
    assign done_res  = o_done_reg;
    assign rx_byte   = o_rx_reg;
    assign ack_seen  = o_ack_reg;

endmodule

>>> rtl/i2cms_chk.sv
// i2cms_chk: port-level checks for the i2c master pin sequencer
// depends on i2cms_pkg; bound to i2c_master_pin_sequencer below
`timescale 1ns / 1ps

module i2cms_chk
    import i2cms_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic              scl_out,
    input logic              sda_out,
    input logic              busy_res,
    input logic              done_res,
    input logic [BYTE_W-1:0] rx_byte,
    input logic              ack_seen
);

    // a finishing word never also reports busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done word reports busy");

    // input side only backs up when the result word is stuck
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(scl_out) && $stable(sda_out)
            && $stable(busy_res) && $stable(done_res) && $stable(rx_byte)
            && $stable(ack_seen))
        else $error("stalled result word changed");

endmodule

bind i2c_master_pin_sequencer i2cms_chk u_i2cms_chk (.*);

>>> tb/sv/tb_i2c_master_pin_sequencer.sv
// tb_i2c_master_pin_sequencer: self-checking bench for the i2c master pin sequencer
// a per-tick bus model predicts every result word; depends on i2cms_pkg and the rtl top
`timescale 1ns / 1ps

module tb_i2c_master_pin_sequencer;
    import i2cms_pkg::*;

    localparam int RUN_LIMIT     = 400000;
    localparam int SETTLE_CYCLES = 4;

    // codes outside the command set, handled as tick only
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        logic              hold;
        logic [CMD_W-1:0]  c;
        logic [BYTE_W-1:0] tx;
        logic              sda;
    } tick_word_t;

    typedef struct packed {
        logic              scl;
        logic              sda;
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] rx;
        logic              ack;
    } bus_word_t;

    typedef struct packed {
        logic [CMD_W-1:0]   op;
        logic [PHASE_W-1:0] phase;
        logic [BYTE_W-1:0]  dly;
        logic [BYTE_W-1:0]  shreg;
        logic [BYTE_W-1:0]  polls;
        logic               scl;
        logic               sda;
        logic               ack;
        logic [BYTE_W-1:0]  rx;
    } bus_state_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic              cfg_index = REG_DELAY_TICKS;
    logic [BYTE_W-1:0] cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [CMD_W-1:0]  cmd = CMD_TICK;
    logic [BYTE_W-1:0] tx_byte = '0;
    logic              sda_in = 1'b1;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              scl_out;
    logic              sda_out;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_seen;

    logic [BYTE_W-1:0] delay_cfg = DELAY_TICKS_RST;
    logic [BYTE_W-1:0] poll_limit_cfg = ACK_POLL_LIMIT_RST;
    bus_state_t        bus_model;
    bus_state_t        plan_model;
    tick_word_t        pending_words[$];
    bus_word_t         expected_words[$];
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                ack_low_pct = 50;
    int                fail_count = 0;
    int                cycle_count = 0;
    bit                word_taken = 1'b0;

    i2c_master_pin_sequencer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .tx_byte   (tx_byte),
        .sda_in    (sda_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .scl_out   (scl_out),
        .sda_out   (sda_out),
        .busy_res  (busy_res),
        .done_res  (done_res),
        .rx_byte   (rx_byte),
        .ack_seen  (ack_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic clear_model(output bus_state_t s);
        s = '0;
        s.op = CMD_TICK;
        s.scl = 1'b1;
        s.sda = 1'b1;
    endtask

    // pin change for the current phase of the running command
    task automatic pin_action(inout bus_state_t s, input logic sda);
        case (s.op)
            CMD_START:
            begin
                if (s.phase == 0) s.sda = 1'b1;
                else if (s.phase == 1) s.scl = 1'b1;
                else s.sda = 1'b0;
            end
            CMD_STOP:
            begin
                if (s.phase == 0) s.sda = 1'b0;
                else if (s.phase == 1) s.scl = 1'b1;
                else s.sda = 1'b1;
            end
            CMD_WRITE:
            begin
                if (s.phase < 24)
                begin
                    case (s.phase % 5'd3)
                        5'd0: s.scl = 1'b0;
                        5'd1:
                        begin
                            s.sda = s.shreg[7];
                            s.shreg = {s.shreg[6:0], 1'b0};
                        end
                        default: s.scl = 1'b1;
                    endcase
                end
                else if (s.phase == 24) s.scl = 1'b0;
                else s.sda = 1'b1;
            end
            CMD_READ:
            begin
                if (s.phase == 0) s.scl = 1'b0;
                else if (s.phase == 1) s.sda = 1'b1;
                else if (!s.phase[0]) s.scl = 1'b1;
                else
                begin
                    s.shreg = {s.shreg[6:0], sda};
                    s.scl = 1'b0;
                end
            end
            CMD_ACK:
            begin
                if (s.phase == 0) s.scl = 1'b1;
                else if (s.phase == 2) s.scl = 1'b0;
            end
            default: ;
        endcase
    endtask

    // advance the bus sequencer by one tick and form the result word
    task automatic step_bus(inout bus_state_t s, input logic [CMD_W-1:0] c,
                            input logic [BYTE_W-1:0] tx, input logic sda,
                            output bus_word_t r);
        logic [BYTE_W-1:0]  hold_val;
        logic [PHASE_W-1:0] last_phase;
        logic               poll_end;
        logic               done;
        hold_val = (delay_cfg == 0) ? 8'd1 : delay_cfg;
        done = 1'b0;
        if (s.op == CMD_TICK)
        begin
            if (c >= CMD_START && c <= CMD_ACK)
            begin
                s.op = c;
                s.phase = '0;
                if (c == CMD_WRITE) s.shreg = tx;
                if (c == CMD_ACK)
                begin
                    s.ack = 1'b0;
                    s.polls = '0;
                end
                pin_action(s, sda);
                s.dly = hold_val;
            end
        end
        else if (s.op == CMD_ACK && s.phase == 1)
        begin
            poll_end = 1'b0;
            if (!sda)
            begin
                s.ack = 1'b1;
                poll_end = 1'b1;
            end
            else if (s.polls >= poll_limit_cfg) poll_end = 1'b1;
            else s.polls = s.polls + 1'b1;
            if (poll_end)
            begin
                s.phase = 5'd2;
                pin_action(s, sda);
                s.dly = hold_val;
            end
        end
        else if (s.dly > 1)
        begin
            s.dly = s.dly - 1'b1;
        end
        else
        begin
            case (s.op)
                CMD_WRITE: last_phase = 5'd26;
                CMD_READ:  last_phase = 5'd18;
                default:   last_phase = 5'd3;
            endcase
            s.phase = s.phase + 1'b1;
            if (s.phase < last_phase)
            begin
                pin_action(s, sda);
                // the poll phase has no hold, it ends on sda
                s.dly = (s.op == CMD_ACK && s.phase == 1) ? 8'd0 : hold_val;
            end
            else
            begin
                if (s.op == CMD_READ) s.rx = s.shreg;
                s.op = CMD_TICK;
                s.phase = '0;
                s.dly = '0;
                done = 1'b1;
            end
        end
        r.scl = s.scl;
        r.sda = s.sda;
        r.busy = (s.op != CMD_TICK);
        r.done = done;
        r.rx = s.rx;
        r.ack = s.ack;
    endtask

    task automatic report_mismatch(input string msg);
        $display("cycle %0d: %s", cycle_count, msg);
        fail_count++;
    endtask

    task automatic push_word(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] tx,
                             input logic sda, input logic hold);
        tick_word_t w;
        bus_word_t  unused;
        w.hold = hold;
        w.c = c;
        w.tx = tx;
        w.sda = sda;
        pending_words.push_back(w);
        step_bus(plan_model, c, tx, sda, unused);
    endtask

    // one command, then ticks at a fixed sda level until it has finished
    task automatic run_command(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] tx,
                               input logic sda);
        push_word(c, tx, sda, 1'b0);
        while (plan_model.op != CMD_TICK)
            push_word(CMD_TICK, BYTE_W'($urandom), sda, 1'b0);
    endtask

    task automatic random_words(input int n);
        int               i;
        logic [CMD_W-1:0] c;
        logic             sda;
        i = 0;
        while (i < n || plan_model.op != CMD_TICK)
        begin
            if (plan_model.op == CMD_TICK)
            begin
                if ($urandom_range(0, 99) < 80) c = CMD_W'($urandom_range(CMD_START, CMD_ACK));
                else c = CMD_W'($urandom_range(0, 7));
                if (c == CMD_ACK)
                begin
                    case ($urandom_range(0, 3))
                        0:       ack_low_pct = 0;
                        1:       ack_low_pct = 2;
                        2:       ack_low_pct = 25;
                        default: ack_low_pct = 100;
                    endcase
                end
            end
            else
            begin
                // commands while busy must be ignored
                c = ($urandom_range(0, 9) == 0) ? CMD_W'($urandom_range(0, 7)) : CMD_TICK;
            end
            if (plan_model.op == CMD_ACK) sda = ($urandom_range(0, 99) >= ack_low_pct);
            else sda = 1'($urandom_range(0, 1));
            push_word(c, BYTE_W'($urandom), sda, $urandom_range(0, 149) == 0);
            i++;
        end
    endtask

    task automatic set_config(input logic [BYTE_W-1:0] dly, input logic [BYTE_W-1:0] lim);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_DELAY_TICKS;
        cfg_data <= dly;
        @(negedge clk);
        cfg_index <= REG_ACK_POLL_LIMIT;
        cfg_data <= lim;
        @(negedge clk);
        cfg_we <= 1'b0;
        delay_cfg = dly;
        poll_limit_cfg = lim;
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // driver: a word stays up until taken
    always @(negedge clk)
    begin : drive_words
        tick_word_t w;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || word_taken)
        begin
            word_taken = 1'b0;
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct
                && !(pending_words[0].hold && expected_words.size() != 0))
            begin
                w = pending_words.pop_front();
                in_valid <= 1'b1;
                cmd <= w.c;
                tx_byte <= w.tx;
                sda_in <= w.sda;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(0, 99) < recv_idle_pct);
    end

    // monitor: predict on every accepted word, check every result word
    always @(posedge clk)
    begin : check_words
        bus_word_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                step_bus(bus_model, cmd, tx_byte, sda_in, want);
                expected_words.push_back(want);
                word_taken = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    report_mismatch("result word with nothing expected");
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (scl_out !== want.scl)
                        report_mismatch($sformatf("scl_out %b, expected %b", scl_out, want.scl));
                    if (sda_out !== want.sda)
                        report_mismatch($sformatf("sda_out %b, expected %b", sda_out, want.sda));
                    if (busy_res !== want.busy)
                        report_mismatch($sformatf("busy_res %b, expected %b", busy_res,
                                                  want.busy));
                    if (done_res !== want.done)
                        report_mismatch($sformatf("done_res %b, expected %b", done_res,
                                                  want.done));
                    if (rx_byte !== want.rx)
                        report_mismatch($sformatf("rx_byte %h, expected %h", rx_byte, want.rx));
                    if (ack_seen !== want.ack)
                        report_mismatch($sformatf("ack_seen %b, expected %b", ack_seen,
                                                  want.ack));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("** i2c_master_pin_sequencer: FAILED **");
            $finish;
        end
    end

    initial
    begin
        clear_model(bus_model);
        clear_model(plan_model);
        send_idle_pct = 18;
        recv_idle_pct = 87;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: half bit of 8, ack poll gives up after 200
        run_command(CMD_TICK, 8'h00, 1'b1);
        run_command(CMD_START, 8'h00, 1'b1);
        run_command(CMD_ACK, 8'h00, 1'b1);
        run_command(CMD_STOP, 8'h00, 1'b0);
        wait_drained();

        // zero delay acts as one, zero poll limit ends on the first poll
        set_config(8'd0, 8'd0);
        run_command(CMD_WRITE, 8'h00, 1'b0);
        run_command(CMD_WRITE, 8'hFF, 1'b1);
        run_command(CMD_WRITE, 8'hA5, 1'b0);
        run_command(CMD_READ, 8'h00, 1'b1);
        run_command(CMD_READ, 8'hFF, 1'b0);
        run_command(CMD_ACK, 8'h00, 1'b1);
        run_command(CMD_ACK, 8'h00, 1'b0);
        push_word(CMD_SPARE_6, 8'h3C, 1'b1, 1'b0);
        push_word(CMD_SPARE_7, 8'hC3, 1'b0, 1'b0);
        // sender waits here until every earlier result has come back
        push_word(CMD_START, 8'h00, 1'b1, 1'b1);
        push_word(CMD_WRITE, 8'h81, 1'b1, 1'b0);
        push_word(CMD_TICK, 8'h00, 1'b1, 1'b0);
        // read on the finishing tick of the start is still ignored
        push_word(CMD_READ, 8'h00, 1'b0, 1'b0);
        run_command(CMD_TICK, 8'h00, 1'b1);
        wait_drained();

        set_config(8'd1, 8'd255);
        random_words(200);
        wait_drained();

        send_idle_pct = 87;
        recv_idle_pct = 18;
        set_config(8'd255, 8'd3);
        run_command(CMD_START, 8'h00, 1'b1);
        wait_drained();

        set_config(8'd2, 8'd0);
        random_words(200);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(8'd3, 8'd17);
        random_words(150);
        wait_drained();

        set_config(BYTE_W'($urandom_range(1, 4)), BYTE_W'($urandom));
        random_words(150);
        wait_drained();

        if (fail_count == 0) $display("** i2c_master_pin_sequencer: PASSED **");
        else $display("** i2c_master_pin_sequencer: FAILED **");
        $finish;
    end

endmodule
